@@ rtl/hms_pkg.sv @@
// Shared operation codes, order codes and time constants for the stopwatch.
`default_nettype none

package hms_pkg;

    // Operation codes carried by an input beat.
    typedef enum logic [2:0] {
        OP_QUERY = 3'd0,
        OP_TICK  = 3'd1,
        OP_CLEAR = 3'd2,
        OP_START = 3'd3,
        OP_STOP  = 3'd4
    } t_op;

    // Three-way order of the current time against the reference time.
    typedef enum logic [1:0] {
        ORD_EARLIER = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_LATER   = 2'd2
    } t_order;

    // Radix of each digit.
    localparam int MS_PER_S  = 1000;
    localparam int S_PER_MIN = 60;
    localparam int MIN_PER_H = 60;

    // Widths of the fixed digits.
    localparam int MS_W  = 10;
    localparam int SEC_W = 6;
    localparam int MIN_W = 6;

    // Widths of the hour fields on the ports.
    localparam int REF_HOUR_W  = 16;
    localparam int DIFF_HOUR_W = 17;

    // Last value of each digit before it carries.
    localparam logic [MS_W-1:0]  MS_LAST  = MS_W'(MS_PER_S - 1);
    localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(S_PER_MIN - 1);
    localparam logic [MIN_W-1:0] MIN_LAST = MIN_W'(MIN_PER_H - 1);

endpackage

`default_nettype wire

@@ rtl/hms_millisecond_stopwatch.sv @@
// Top level of the hours/minutes/seconds/milliseconds stopwatch.
`default_nettype none

// The stopwatch takes one beat per clock cycle while it is not stalled and returns one result
// beat per input beat, in order. A beat is held in an input register, then the operation
// updates the time count and the difference to the reference is formed in one pass of logic
// that loads the result register, from which the result beat is presented. The rate is one
// beat per cycle while the result side is not stalled, as the combinational count update
// feeds the next beat. While the result register is stalled the input register still takes
// one more beat. Hours wrap at HOUR_WIDTH bits; the reported hours are the low 16 bits of
// the count.
module hms_millisecond_stopwatch #(
    parameter int HOUR_WIDTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [2:0]                           i_operation,
    input  wire logic [hms_pkg::REF_HOUR_W-1:0]       i_ref_hours,
    input  wire logic [hms_pkg::MIN_W-1:0]            i_ref_minutes,
    input  wire logic [hms_pkg::SEC_W-1:0]            i_ref_seconds,
    input  wire logic [hms_pkg::MS_W-1:0]             i_ref_milliseconds,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic                                      o_is_running,
    output logic [hms_pkg::REF_HOUR_W-1:0]            o_now_hours,
    output logic [hms_pkg::MIN_W-1:0]                 o_now_minutes,
    output logic [hms_pkg::SEC_W-1:0]                 o_now_seconds,
    output logic [hms_pkg::MS_W-1:0]                  o_now_milliseconds,
    output logic signed [hms_pkg::DIFF_HOUR_W-1:0]    o_diff_hours,
    output logic [hms_pkg::MIN_W-1:0]                 o_diff_minutes,
    output logic [hms_pkg::SEC_W-1:0]                 o_diff_seconds,
    output logic [hms_pkg::MS_W-1:0]                  o_diff_milliseconds,
    output logic [1:0]                                o_order
);
    import hms_pkg::*;

    localparam int HX = (HOUR_WIDTH > REF_HOUR_W) ? HOUR_WIDTH : REF_HOUR_W;

    // Input register.
    logic                   r_in_valid;
    logic [2:0]             r_op;
    logic [REF_HOUR_W-1:0]  r_ref_hours;
    logic [MIN_W-1:0]       r_ref_minutes;
    logic [SEC_W-1:0]       r_ref_seconds;
    logic [MS_W-1:0]        r_ref_ms;

    // Time count and running flag.
    logic [HOUR_WIDTH-1:0]  r_hours;
    logic [MIN_W-1:0]       r_minutes;
    logic [SEC_W-1:0]       r_seconds;
    logic [MS_W-1:0]        r_ms;
    logic                   r_run;
    logic [HOUR_WIDTH-1:0]  n_hours;
    logic [MIN_W-1:0]       n_minutes;
    logic [SEC_W-1:0]       n_seconds;
    logic [MS_W-1:0]        n_ms;
    logic                   n_run;

    // Result register.
    logic                          r_out_valid;
    logic                          r_is_running;
    logic [REF_HOUR_W-1:0]         r_now_hours;
    logic [MIN_W-1:0]              r_now_minutes;
    logic [SEC_W-1:0]              r_now_seconds;
    logic [MS_W-1:0]               r_now_ms;
    logic signed [DIFF_HOUR_W-1:0] r_diff_hours;
    logic [MIN_W-1:0]              r_diff_minutes;
    logic [SEC_W-1:0]              r_diff_seconds;
    logic [MS_W-1:0]               r_diff_ms;
    t_order                        r_order;

    logic signed [DIFF_HOUR_W-1:0] diff_hours;
    logic [MIN_W-1:0]              diff_minutes;
    logic [SEC_W-1:0]              diff_seconds;
    logic [MS_W-1:0]               diff_ms;
    t_order                        diff_order;
    logic [HX-1:0]                 hours_ext;

    logic advance;
    logic in_accept;
    logic fire;

    // Handshake: the result register moves when empty or taken downstream.
    assign advance   = !r_out_valid || !i_stall;
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;
    assign fire      = r_in_valid && advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op          <= i_operation;
            r_ref_hours   <= i_ref_hours;
            r_ref_minutes <= i_ref_minutes;
            r_ref_seconds <= i_ref_seconds;
            r_ref_ms      <= i_ref_milliseconds;
        end
    end

    // Next count: cascaded carries on a tick while running.
    always_comb begin
        n_hours   = r_hours;
        n_minutes = r_minutes;
        n_seconds = r_seconds;
        n_ms      = r_ms;
        n_run     = r_run;
        unique case (r_op)
            OP_TICK: begin
                if (r_run) begin
                    if (r_ms == MS_LAST) begin
                        n_ms = '0;
                        if (r_seconds == SEC_LAST) begin
                            n_seconds = '0;
                            if (r_minutes == MIN_LAST) begin
                                n_minutes = '0;
                                n_hours   = r_hours + {{(HOUR_WIDTH-1){1'b0}}, 1'b1};
                            end else begin
                                n_minutes = r_minutes + {{(MIN_W-1){1'b0}}, 1'b1};
                            end
                        end else begin
                            n_seconds = r_seconds + {{(SEC_W-1){1'b0}}, 1'b1};
                        end
                    end else begin
                        n_ms = r_ms + {{(MS_W-1){1'b0}}, 1'b1};
                    end
                end
            end
            OP_CLEAR: begin
                n_hours   = '0;
                n_minutes = '0;
                n_seconds = '0;
                n_ms      = '0;
            end
            OP_START: n_run = 1'b1;
            OP_STOP:  n_run = 1'b0;
            default:  ;
        endcase
    end

    // Count registers update once per beat leaving the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hours   <= '0;
            r_minutes <= '0;
            r_seconds <= '0;
            r_ms      <= '0;
            r_run     <= 1'b0;
        end else if (fire) begin
            r_hours   <= n_hours;
            r_minutes <= n_minutes;
            r_seconds <= n_seconds;
            r_ms      <= n_ms;
            r_run     <= n_run;
        end
    end

    // Difference of the updated time against the beat's reference.
    hms_diff #(
        .HOUR_WIDTH (HOUR_WIDTH)
    ) u_diff (
        .i_now_hours         (n_hours),
        .i_now_minutes       (n_minutes),
        .i_now_seconds       (n_seconds),
        .i_now_milliseconds  (n_ms),
        .i_ref_hours         (r_ref_hours),
        .i_ref_minutes       (r_ref_minutes),
        .i_ref_seconds       (r_ref_seconds),
        .i_ref_milliseconds  (r_ref_ms),
        .o_diff_hours        (diff_hours),
        .o_diff_minutes      (diff_minutes),
        .o_diff_seconds      (diff_seconds),
        .o_diff_milliseconds (diff_ms),
        .o_order             (diff_order)
    );

    assign hours_ext = HX'(n_hours);

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_is_running   <= n_run;
            r_now_hours    <= hours_ext[REF_HOUR_W-1:0];
            r_now_minutes  <= n_minutes;
            r_now_seconds  <= n_seconds;
            r_now_ms       <= n_ms;
            r_diff_hours   <= diff_hours;
            r_diff_minutes <= diff_minutes;
            r_diff_seconds <= diff_seconds;
            r_diff_ms      <= diff_ms;
            r_order        <= diff_order;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_is_running        = r_is_running;
    assign o_now_hours         = r_now_hours;
    assign o_now_minutes       = r_now_minutes;
    assign o_now_seconds       = r_now_seconds;
    assign o_now_milliseconds  = r_now_ms;
    assign o_diff_hours        = r_diff_hours;
    assign o_diff_minutes      = r_diff_minutes;
    assign o_diff_seconds      = r_diff_seconds;
    assign o_diff_milliseconds = r_diff_ms;
    assign o_order             = r_order;

`ifndef SYNTH
    // The lower digits of the count never leave their radix.
    a_digits_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ms <= MS_LAST) && (r_seconds <= SEC_LAST) && (r_minutes <= MIN_LAST))
        else $error("stopwatch digit out of range");

    // A tick while stopped leaves the count untouched.
    a_stopped_tick_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_run && r_op == OP_TICK) |=>
            ($stable(r_ms) && $stable(r_seconds) && $stable(r_minutes) && $stable(r_hours)))
        else $error("count moved on a tick while stopped");

    // Equal order means a zero difference in every digit.
    a_equal_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_order == ORD_EQUAL) |->
            (r_diff_hours == '0 && r_diff_minutes == '0 && r_diff_seconds == '0
             && r_diff_ms == '0))
        else $error("equal order with nonzero difference");

    // The count changes only when a beat leaves the input register.
    a_count_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> ($stable(r_ms) && $stable(r_hours) && $stable(r_run)))
        else $error("count changed without a beat");

    // A stalled result with a waiting beat keeps the input side stalled.
    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_stall) |-> o_stall)
        else $error("input not stalled while both stages are full");
`endif

endmodule

`default_nettype wire

@@ rtl/hms_diff.sv @@
// Mixed-radix difference of current and reference time with floor borrows and order.
`default_nettype none

module hms_diff #(
    parameter int HOUR_WIDTH = 16
) (
    input  wire logic [HOUR_WIDTH-1:0]               i_now_hours,
    input  wire logic [hms_pkg::MIN_W-1:0]           i_now_minutes,
    input  wire logic [hms_pkg::SEC_W-1:0]           i_now_seconds,
    input  wire logic [hms_pkg::MS_W-1:0]            i_now_milliseconds,
    input  wire logic [hms_pkg::REF_HOUR_W-1:0]      i_ref_hours,
    input  wire logic [hms_pkg::MIN_W-1:0]           i_ref_minutes,
    input  wire logic [hms_pkg::SEC_W-1:0]           i_ref_seconds,
    input  wire logic [hms_pkg::MS_W-1:0]            i_ref_milliseconds,
    output logic signed [hms_pkg::DIFF_HOUR_W-1:0]   o_diff_hours,
    output logic [hms_pkg::MIN_W-1:0]                o_diff_minutes,
    output logic [hms_pkg::SEC_W-1:0]                o_diff_seconds,
    output logic [hms_pkg::MS_W-1:0]                 o_diff_milliseconds,
    output hms_pkg::t_order                          o_order
);
    import hms_pkg::*;

    // Hour arithmetic is wide enough for either operand plus the borrow and a sign.
    localparam int HX = (HOUR_WIDTH > REF_HOUR_W) ? HOUR_WIDTH : REF_HOUR_W;
    localparam int DW = HX + 2;

    logic signed [MS_W+1:0]  ms_raw;
    logic signed [MS_W+1:0]  ms_adj;
    logic [1:0]              ms_borrow;
    logic signed [SEC_W+1:0] sec_raw;
    logic signed [SEC_W+1:0] sec_adj;
    logic [1:0]              sec_borrow;
    logic signed [MIN_W+1:0] min_raw;
    logic signed [MIN_W+1:0] min_adj;
    logic [1:0]              min_borrow;
    logic signed [DW-1:0]    hour_raw;

    // Milliseconds: the raw difference lies in -1023..999, so at most two borrows.
    always_comb begin
        ms_raw = $signed({2'b00, i_now_milliseconds}) - $signed({2'b00, i_ref_milliseconds});
        if (ms_raw < -(MS_W+2)'(MS_PER_S)) begin
            ms_adj    = ms_raw + (MS_W+2)'(2 * MS_PER_S);
            ms_borrow = 2'd2;
        end else if (ms_raw < 0) begin
            ms_adj    = ms_raw + (MS_W+2)'(MS_PER_S);
            ms_borrow = 2'd1;
        end else begin
            ms_adj    = ms_raw;
            ms_borrow = 2'd0;
        end
    end

    // Seconds: raw difference lies in -65..59.
    always_comb begin
        sec_raw = $signed({2'b00, i_now_seconds}) - $signed({2'b00, i_ref_seconds})
                - $signed({{SEC_W{1'b0}}, ms_borrow});
        if (sec_raw < -(SEC_W+2)'(S_PER_MIN)) begin
            sec_adj    = sec_raw + (SEC_W+2)'(2 * S_PER_MIN);
            sec_borrow = 2'd2;
        end else if (sec_raw < 0) begin
            sec_adj    = sec_raw + (SEC_W+2)'(S_PER_MIN);
            sec_borrow = 2'd1;
        end else begin
            sec_adj    = sec_raw;
            sec_borrow = 2'd0;
        end
    end

    // Minutes: same range as seconds.
    always_comb begin
        min_raw = $signed({2'b00, i_now_minutes}) - $signed({2'b00, i_ref_minutes})
                - $signed({{MIN_W{1'b0}}, sec_borrow});
        if (min_raw < -(MIN_W+2)'(MIN_PER_H)) begin
            min_adj    = min_raw + (MIN_W+2)'(2 * MIN_PER_H);
            min_borrow = 2'd2;
        end else if (min_raw < 0) begin
            min_adj    = min_raw + (MIN_W+2)'(MIN_PER_H);
            min_borrow = 2'd1;
        end else begin
            min_adj    = min_raw;
            min_borrow = 2'd0;
        end
    end

    // Hours take the final borrow; the result is the floor hour quotient.
    assign hour_raw = $signed(DW'(i_now_hours)) - $signed(DW'(i_ref_hours))
                    - $signed(DW'(min_borrow));

    assign o_diff_hours        = hour_raw[DIFF_HOUR_W-1:0];
    assign o_diff_minutes      = min_adj[MIN_W-1:0];
    assign o_diff_seconds      = sec_adj[SEC_W-1:0];
    assign o_diff_milliseconds = ms_adj[MS_W-1:0];

    // The total difference is negative exactly when the floor hours are negative.
    always_comb begin
        if (hour_raw[DW-1]) begin
            o_order = ORD_EARLIER;
        end else if (hour_raw == '0 && min_adj == '0 && sec_adj == '0 && ms_adj == '0) begin
            o_order = ORD_EQUAL;
        end else begin
            o_order = ORD_LATER;
        end
    end

endmodule

`default_nettype wire
